/* sv/demand_paging_fifo_translator_assert.svh */
// Assertion macros for the translator RTL, used by the table unit (dpft_back).
`ifndef DEMAND_PAGING_FIFO_TRANSLATOR_ASSERT_SVH
`define DEMAND_PAGING_FIFO_TRANSLATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DPFT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define DPFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/dpft_pkg.sv */
package dpft_pkg;

  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned PADDR_W     = 13;
  localparam int unsigned FRAME_OUT_W = 5;
  localparam int unsigned PAGE_OUT_W  = 8;

  localparam int unsigned DEF_PAGE_SIZE  = 256;
  localparam int unsigned DEF_NUM_FRAMES = 32;
  localparam int unsigned DEF_NUM_PAGES  = 256;

  localparam int unsigned TDATA_IN_W  = 24;
  localparam int unsigned TDATA_OUT_W = 40;

  // Decoded access as it waits between the front and the back.
  typedef struct packed {
    logic [DATA_W-1:0] write_data;
    logic              is_write;
    logic [ADDR_W-1:0] logical_address;
  } req_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic [DATA_W-1:0]      memory_data;
    logic                   memory_write;
    logic                   writeback_needed;
    logic [PAGE_OUT_W-1:0]  evicted_page;
    logic                   evicted;
    logic                   page_fault;
    logic [FRAME_OUT_W-1:0] frame_number;
    logic [PADDR_W-1:0]     physical_address;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);
  localparam int unsigned PAD_W = TDATA_OUT_W - RES_W;

  typedef enum logic {
    ST_LOOK,
    ST_DO
  } back_state_t;

endpackage

/* sv/dpft_ram.sv */
module dpft_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/dpft_front.sv */
module dpft_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [dpft_pkg::TDATA_IN_W-1:0] s_tdata,
  input  logic                            s_tuser,
  output logic                            q_valid,
  input  logic                            q_ready,
  output dpft_pkg::req_t                  q_item
);

  import dpft_pkg::*;

  logic [1:0] cnt;
  logic       wp;
  logic       rp;
  req_t       slot [2];
  req_t       decoded;
  logic       push;
  logic       pop;

  // The data byte only matters on a write, so reads carry zero downstream.
  always_comb begin
    decoded.logical_address = s_tdata[ADDR_W-1:0];
    decoded.is_write        = s_tuser;
    decoded.write_data      = s_tuser ? s_tdata[ADDR_W +: DATA_W] : '0;
  end

  assign s_tready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = slot[rp];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= decoded;
    end
  end

endmodule

/* sv/dpft_back.sv */
module dpft_back #(
  parameter int unsigned PAGE_SIZE  = dpft_pkg::DEF_PAGE_SIZE,
  parameter int unsigned NUM_FRAMES = dpft_pkg::DEF_NUM_FRAMES,
  parameter int unsigned NUM_PAGES  = dpft_pkg::DEF_NUM_PAGES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  output logic                             q_ready,
  input  dpft_pkg::req_t                   q_item,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [dpft_pkg::TDATA_OUT_W-1:0] m_tdata
);

  import dpft_pkg::*;

  `include "demand_paging_fifo_translator_assert.svh"

  localparam int unsigned OFF_W  = $clog2(PAGE_SIZE);
  localparam int unsigned PG_W   = $clog2(NUM_PAGES);
  localparam int unsigned FR_W   = $clog2(NUM_FRAMES);
  localparam int unsigned FILL_W = $clog2(NUM_FRAMES + 1);

  back_state_t          state;
  back_state_t          state_next;
  logic [NUM_PAGES-1:0] valid_bits;
  logic [FILL_W-1:0]    filled;
  logic [FR_W-1:0]      ptr;
  logic [FR_W-1:0]      ptr_next;
  logic [FR_W-1:0]      pf_rdata;
  logic [PG_W-1:0]      own_rdata;
  logic                 dirty_rdata;
  logic                 rd_en;
  logic                 out_valid;
  res_t                 out_data;
  res_t                 res_next;

  logic [31:0]      addr_wide;
  logic [PG_W-1:0]  page;
  logic [OFF_W-1:0] offset;
  logic             hit;
  logic             full;
  logic             evict;
  logic [FR_W-1:0]  frame;
  logic [31:0]      frame_wide;
  logic [31:0]      old_wide;
  logic [31:0]      paddr_wide;
  logic             out_free;
  logic             commit;
  logic             map_we;
  logic             dirty_we;

  assign addr_wide = 32'(q_item.logical_address);
  assign page      = PG_W'(addr_wide >> OFF_W);
  assign offset    = q_item.logical_address[OFF_W-1:0];

  assign hit   = valid_bits[page];
  assign full  = (filled == FILL_W'(NUM_FRAMES));
  assign evict = !hit && full;

  // A hit reuses the stored frame; a miss takes the next unused frame, and
  // once all are in use, the frame under the replacement pointer.
  always_comb begin
    if (hit) begin
      frame = pf_rdata;
    end else if (!full) begin
      frame = filled[FR_W-1:0];
    end else begin
      frame = ptr;
    end
  end

  assign ptr_next = (ptr == FR_W'(NUM_FRAMES - 1)) ? '0 : ptr + FR_W'(1);

  assign frame_wide = 32'(frame);
  assign old_wide   = 32'(own_rdata);
  assign paddr_wide = (frame_wide << OFF_W) | 32'(offset);

  always_comb begin
    res_next.physical_address = paddr_wide[PADDR_W-1:0];
    res_next.frame_number     = frame_wide[FRAME_OUT_W-1:0];
    res_next.page_fault       = !hit;
    res_next.evicted          = evict;
    res_next.evicted_page     = evict ? old_wide[PAGE_OUT_W-1:0] : '0;
    res_next.writeback_needed = evict && dirty_rdata;
    res_next.memory_write     = q_item.is_write;
    res_next.memory_data      = q_item.write_data;
  end

  assign out_free = !out_valid || m_tready;
  assign commit   = (state == ST_DO) && out_free;
  assign map_we   = commit && !hit;
  // A new mapping rewrites its frame's dirty bit, so a victim never needs
  // clearing; a hit only touches the bit on a write.
  assign dirty_we = commit && (!hit || q_item.is_write);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOOK;
    end else begin
      state <= state_next;
    end
  end

  // ST_LOOK reads the three tables; ST_DO decides and writes back once the output is free.
  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    rd_en      = 1'b0;
    unique case (state)
      ST_LOOK: begin
        if (q_valid) begin
          rd_en      = 1'b1;
          state_next = ST_DO;
        end
      end
      ST_DO: begin
        if (out_free) begin
          q_ready    = 1'b1;
          state_next = ST_LOOK;
        end
      end
      default: begin
        state_next = ST_LOOK;
      end
    endcase
  end

  dpft_ram #(
    .WIDTH(FR_W),
    .DEPTH(NUM_PAGES)
  ) u_page_frame (
    .clk  (clk),
    .we   (map_we),
    .waddr(page),
    .wdata(frame),
    .re   (rd_en),
    .raddr(page),
    .rdata(pf_rdata)
  );

  dpft_ram #(
    .WIDTH(PG_W),
    .DEPTH(NUM_FRAMES)
  ) u_frame_owner (
    .clk  (clk),
    .we   (map_we),
    .waddr(frame),
    .wdata(page),
    .re   (rd_en),
    .raddr(ptr),
    .rdata(own_rdata)
  );

  dpft_ram #(
    .WIDTH(1),
    .DEPTH(NUM_FRAMES)
  ) u_frame_dirty (
    .clk  (clk),
    .we   (dirty_we),
    .waddr(frame),
    .wdata(q_item.is_write),
    .re   (rd_en),
    .raddr(ptr),
    .rdata(dirty_rdata)
  );

  // The victim is cleared first so that the new mapping wins on equal index.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      filled     <= '0;
      ptr        <= '0;
    end else if (commit) begin
      if (evict) begin
        valid_bits[own_rdata] <= 1'b0;
        ptr                   <= ptr_next;
      end else if (!hit) begin
        filled <= filled + FILL_W'(1);
      end
      valid_bits[page] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{PAD_W{1'b0}}, out_data};

  `DPFT_ASSERT_IMPL(a_fill_bound, clk, rst, 1'b1, filled <= FILL_W'(NUM_FRAMES), "frame count overrun")
  `DPFT_ASSERT_IMPL(a_ptr_idle, clk, rst, !full, ptr == '0, "replacement pointer moved early")
  `DPFT_ASSERT_NEXT(a_commit_out, clk, rst, commit, out_valid, "result lost after commit")
  `DPFT_ASSERT_IMPL(a_evict_fault, clk, rst, out_valid && out_data.evicted, out_data.page_fault, "eviction without fault")

endmodule

/* sv/demand_paging_fifo_translator.sv */
// Channel  Dir  Fields (tdata from bit 0 up)                          Sideband
// s_*      in   logical_address[15:0], write_data[23:16]              tuser = is_write
// m_*      out  physical_address[12:0], frame_number[17:13],          none
//               page_fault[18], evicted[19], evicted_page[27:20],
//               writeback_needed[28], memory_write[29], memory_data[37:30]
//
// Each item passes through two states in the table unit: ST_LOOK reads the
// page-frame, frame-owner and dirty memories, ST_DO decides the mapping and
// writes it back. No new item is taken before that read-then-update pass ends.
// A two-item queue in front takes items while the table unit works, until full.
// Reset clears the valid bits, the fill count and the pointer at once;
// a stalled result holds in the output register and stops the table unit.
module demand_paging_fifo_translator #(
  parameter int unsigned PAGE_SIZE  = dpft_pkg::DEF_PAGE_SIZE,
  parameter int unsigned NUM_FRAMES = dpft_pkg::DEF_NUM_FRAMES,
  parameter int unsigned NUM_PAGES  = dpft_pkg::DEF_NUM_PAGES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // logical_address, write_data
  input  logic [dpft_pkg::TDATA_IN_W-1:0]  s_tdata,
  // is_write
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // physical_address, frame_number, page_fault, evicted, evicted_page,
  // writeback_needed, memory_write, memory_data
  output logic [dpft_pkg::TDATA_OUT_W-1:0] m_tdata
);

  import dpft_pkg::*;

  logic q_valid;
  logic q_ready;
  req_t q_item;

  dpft_front u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  dpft_back #(
    .PAGE_SIZE (PAGE_SIZE),
    .NUM_FRAMES(NUM_FRAMES),
    .NUM_PAGES (NUM_PAGES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule
